/* rtl/pptsu_pkg.sv */
// pptsu_pkg: shared types, codes and the control store of the period sequencer
// used by pptsu_seq, pptsu_dp and pwm_period_trajectory_sequencer_unit
package pptsu_pkg;

	localparam int PC_W      = 6;
	localparam int CFG_IDX_W = 3;
	localparam int WORD_W    = 16;
	localparam int WADDR_W   = 10;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MARK_BE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_NORM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_LOOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_REV  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY      = 3'd4;

	localparam logic [WORD_W-1:0] CMP_STOP    = 16'hFFFF;
	localparam logic [WORD_W-1:0] DUTY_RESET  = 16'd40;

	typedef struct packed {
		logic [WORD_W-1:0] mk_be;
		logic [WORD_W-1:0] mk_norm;
		logic [WORD_W-1:0] mk_loop;
		logic [WORD_W-1:0] mk_rev;
		logic [WORD_W-1:0] duty;
	} cfg_t;

	typedef enum logic [1:0] {
		PLAY_NORMAL = 2'd0,
		PLAY_LOOP   = 2'd1,
		PLAY_REV    = 2'd2
	} play_t;

	// read address source
	typedef enum logic [1:0] {
		A_PTR   = 2'd0,
		A_FWD   = 2'd1,
		A_BACK  = 2'd2,
		A_CONST = 2'd3
	} asel_t;

	typedef enum logic [3:0] {
		D_NONE        = 4'd0,
		D_CLR_RUN     = 4'd1,
		D_SAVE_W      = 4'd2,
		D_SET_ERR     = 4'd3,
		D_LD_PEND_LPP = 4'd4,
		D_LIM_HI      = 4'd5,
		D_LIM_LO      = 4'd6,
		D_LD_PEND     = 4'd7,
		D_SET_PRE     = 4'd8,
		D_GO          = 4'd9,
		D_TOP_PEND    = 4'd10,
		D_LD_LOOPP    = 4'd11,
		D_LOOP_STEP   = 4'd12,
		D_SET_NOW     = 4'd13,
		D_STOP_STEP   = 4'd14
	} dop_t;

	typedef enum logic [2:0] {
		P_HOLD  = 3'd0,
		P_FWD   = 3'd1,
		P_BACK  = 3'd2,
		P_CONST = 3'd3,
		P_MOD   = 3'd4
	} pop_t;

	typedef enum logic [1:0] {
		M_HOLD   = 2'd0,
		M_NORMAL = 2'd1,
		M_LOOP   = 2'd2,
		M_REV    = 2'd3
	} mop_t;

	typedef enum logic [3:0] {
		C_NEXT       = 4'd0,
		C_ALWAYS     = 4'd1,
		C_RD_NE_BE   = 4'd2,
		C_RD_EQ_REV  = 4'd3,
		C_RD_EQ_LOOP = 4'd4,
		C_RD_EQ_NORM = 4'd5,
		C_RD_NE_NORM = 4'd6,
		C_W_EQ_LOOP  = 4'd7,
		C_W_EQ_NORM  = 4'd8,
		C_STOP_NOW   = 4'd9,
		C_STOP_PRE   = 4'd10,
		C_MODE_LOOP  = 4'd11,
		C_MODE_REV   = 4'd12,
		C_CNT_NE_LIM = 4'd13
	} cond_t;

	typedef struct packed {
		logic            rd;
		asel_t           asel;
		logic [2:0]      k;
		dop_t            dop;
		pop_t            pop;
		mop_t            mop;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            last;
	} uctl_t;

	typedef struct packed {
		logic  wr;
		logic  step;
		uctl_t uw;
	} seq_ctl_t;

	typedef struct packed {
		logic take;
		logic active;
	} dp_status_t;

	typedef struct packed {
		logic [WORD_W-1:0] period_top;
		logic [WORD_W-1:0] compare_value;
		logic              timer_running;
		logic              sequence_active;
		logic [1:0]        error_code;
	} res_t;

	// program labels
	localparam logic [PC_W-1:0] L_START = 6'd0;
	localparam logic [PC_W-1:0] L_E3    = 6'd5;
	localparam logic [PC_W-1:0] L_E1    = 6'd6;
	localparam logic [PC_W-1:0] L_E2    = 6'd7;
	localparam logic [PC_W-1:0] L_LS0   = 6'd8;
	localparam logic [PC_W-1:0] L_NS0   = 6'd11;
	localparam logic [PC_W-1:0] L_GO    = 6'd14;
	localparam logic [PC_W-1:0] L_TICK  = 6'd15;
	localparam logic [PC_W-1:0] L_PREE  = 6'd24;
	localparam logic [PC_W-1:0] L_DONE  = 6'd25;
	localparam logic [PC_W-1:0] L_NL0   = 6'd26;
	localparam logic [PC_W-1:0] L_MR0   = 6'd30;
	localparam logic [PC_W-1:0] L_L0    = 6'd35;
	localparam logic [PC_W-1:0] L_TSP   = 6'd40;
	localparam logic [PC_W-1:0] L_LN    = 6'd41;
	localparam logic [PC_W-1:0] L_R0    = 6'd42;
	localparam logic [PC_W-1:0] L_TSN   = 6'd48;
	localparam logic [PC_W-1:0] L_LAST  = 6'd48;

	function automatic uctl_t uc(input logic rd, input asel_t a, input logic [2:0] k,
			input dop_t d, input pop_t p, input mop_t m, input cond_t c,
			input logic [PC_W-1:0] t, input logic last);
		uctl_t w;
		w.rd = rd; w.asel = a; w.k = k; w.dop = d; w.pop = p; w.mop = m;
		w.cond = c; w.target = t; w.last = last;
		return w;
	endfunction

	function automatic uctl_t ucode(input logic [PC_W-1:0] pc);
		uctl_t w;
		case (pc)
			// start: header check, first segment setup and launch
			6'd0:  w = uc(1, A_CONST, 0, D_NONE, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd1:  w = uc(1, A_CONST, 1, D_CLR_RUN, P_HOLD, M_HOLD, C_RD_NE_BE, L_E1, 0);
			6'd2:  w = uc(1, A_CONST, 2, D_SAVE_W, P_HOLD, M_HOLD, C_RD_EQ_REV, L_E2, 0);
			6'd3:  w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_W_EQ_LOOP, L_LS0, 0);
			6'd4:  w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_W_EQ_NORM, L_NS0, 0);
			6'd5:  w = uc(0, A_PTR, 3, D_SET_ERR, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
			6'd6:  w = uc(0, A_PTR, 1, D_SET_ERR, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
			6'd7:  w = uc(0, A_PTR, 2, D_SET_ERR, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
			6'd8:  w = uc(1, A_CONST, 3, D_LD_PEND_LPP, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd9:  w = uc(1, A_CONST, 4, D_LIM_HI, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd10: w = uc(0, A_PTR, 5, D_LIM_LO, P_CONST, M_LOOP, C_ALWAYS, L_GO, 0);
			6'd11: w = uc(1, A_CONST, 3, D_LD_PEND, P_CONST, M_NORMAL, C_NEXT, L_START, 0);
			6'd12: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_RD_NE_BE, L_GO, 0);
			6'd13: w = uc(0, A_PTR, 0, D_SET_PRE, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd14: w = uc(0, A_PTR, 0, D_GO, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
			// tick: dispatch
			6'd15: w = uc(0, A_PTR, 0, D_TOP_PEND, P_HOLD, M_HOLD, C_STOP_NOW, L_TSN, 0);
			6'd16: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_STOP_PRE, L_TSP, 0);
			6'd17: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_MODE_LOOP, L_L0, 0);
			6'd18: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_MODE_REV, L_R0, 0);
			// normal walk
			6'd19: w = uc(1, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd20: w = uc(1, A_FWD, 0, D_LD_PEND, P_FWD, M_HOLD, C_NEXT, L_START, 0);
			6'd21: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_RD_EQ_REV, L_MR0, 0);
			6'd22: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_RD_EQ_LOOP, L_NL0, 0);
			6'd23: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_RD_NE_BE, L_DONE, 0);
			6'd24: w = uc(0, A_PTR, 0, D_SET_PRE, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
			6'd25: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
			// loop segment header
			6'd26: w = uc(1, A_FWD, 0, D_NONE, P_FWD, M_HOLD, C_NEXT, L_START, 0);
			6'd27: w = uc(1, A_FWD, 0, D_LD_LOOPP, P_FWD, M_HOLD, C_NEXT, L_START, 0);
			6'd28: w = uc(1, A_FWD, 0, D_LIM_HI, P_FWD, M_HOLD, C_NEXT, L_START, 0);
			6'd29: w = uc(0, A_PTR, 0, D_LIM_LO, P_FWD, M_LOOP, C_NEXT, L_START, 1);
			// reverse jump: fetch pointer, reduce it modulo the depth
			6'd30: w = uc(1, A_FWD, 0, D_NONE, P_HOLD, M_REV, C_NEXT, L_START, 0);
			6'd31: w = uc(0, A_PTR, 0, D_SAVE_W, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd32: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd33: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd34: w = uc(0, A_PTR, 0, D_NONE, P_MOD, M_HOLD, C_NEXT, L_START, 1);
			// loop repeat
			6'd35: w = uc(1, A_PTR, 0, D_LOOP_STEP, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd36: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_CNT_NE_LIM, L_DONE, 0);
			6'd37: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_RD_EQ_NORM, L_LN, 0);
			6'd38: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_RD_EQ_REV, L_MR0, 0);
			6'd39: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_RD_NE_BE, L_DONE, 0);
			6'd40: w = uc(0, A_PTR, 0, D_SET_NOW, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
			6'd41: w = uc(0, A_PTR, 0, D_NONE, P_FWD, M_NORMAL, C_NEXT, L_START, 1);
			// reverse walk
			6'd42: w = uc(1, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_NEXT, L_START, 0);
			6'd43: w = uc(1, A_BACK, 0, D_LD_PEND, P_BACK, M_HOLD, C_NEXT, L_START, 0);
			6'd44: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_RD_NE_NORM, L_DONE, 0);
			6'd45: w = uc(1, A_BACK, 0, D_NONE, P_BACK, M_HOLD, C_NEXT, L_START, 0);
			6'd46: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_RD_NE_BE, L_DONE, 0);
			6'd47: w = uc(0, A_PTR, 0, D_SET_PRE, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
			// two-tick stop
			6'd48: w = uc(0, A_PTR, 0, D_STOP_STEP, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
			default: w = uc(0, A_PTR, 0, D_NONE, P_HOLD, M_HOLD, C_NEXT, L_START, 1);
		endcase
		return w;
	endfunction

endpackage

/* rtl/pwm_period_trajectory_sequencer_unit.sv */
// pwm_period_trajectory_sequencer_unit: top level, stream ports, marker and duty registers
// uses pptsu_pkg, pptsu_seq and pptsu_dp
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tdata (address, word), s_tuser (func)
//  m_       out        m_tvalid/m_tready  m_tdata (top, compare, flags, error)
//  cfg_     in         cfg_we             cfg_index, cfg_data
//
// one item at a time: a start or a tick runs control store steps (at most one store
// read per step), then the result is handed over; the block is ready again the cycle
// after the result is taken.
// reset clears all control and sequence state; store contents stay undefined.
// a stalled output holds the block; no item is taken until the result leaves.
module pwm_period_trajectory_sequencer_unit
	import pptsu_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // word_address[9:0], word_data[25:10], zero
	input  logic [1:0]           s_tuser,   // func[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // period_top[15:0], compare_value[31:16],
	                                        // timer_running[32], sequence_active[33],
	                                        // error_code[35:34], zero
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	cfg_t       cfg_q;
	seq_ctl_t   seq;
	dp_status_t status;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mk_be   <= 16'd0;
			cfg_q.mk_norm <= 16'd1;
			cfg_q.mk_loop <= 16'd2;
			cfg_q.mk_rev  <= 16'd3;
			cfg_q.duty    <= DUTY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MARK_BE:   cfg_q.mk_be   <= cfg_data;
				CFG_MARK_NORM: cfg_q.mk_norm <= cfg_data;
				CFG_MARK_LOOP: cfg_q.mk_loop <= cfg_data;
				CFG_MARK_REV:  cfg_q.mk_rev  <= cfg_data;
				CFG_DUTY:      cfg_q.duty    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pptsu_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.func      (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.seq       (seq)
	);

	pptsu_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.seq     (seq),
		.cfg     (cfg_q),
		.wr_addr (s_tdata[9:0]),
		.wr_data (s_tdata[25:10]),
		.status  (status),
		.res     (res)
	);

	assign m_tdata = {4'b0, res.error_code, res.sequence_active, res.timer_running,
		res.compare_value, res.period_top};

endmodule

/* rtl/pptsu_seq.sv */
// pptsu_seq: item dispatch, step counter and control store lookup
// depends on pptsu_pkg
module pptsu_seq
	import pptsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output seq_ctl_t   seq
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t          state_q;
	logic [PC_W-1:0] pc_q;
	uctl_t           uw;
	logic            acc;

	assign uw        = ucode(pc_q);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign acc       = in_valid && in_ready;

	assign seq.wr   = acc && (func == FUNC_WRITE);
	assign seq.step = (state_q == ST_RUN);
	assign seq.uw   = uw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= L_START;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (func == FUNC_START) begin
							pc_q    <= L_START;
							state_q <= ST_RUN;
						end else if (func == FUNC_TICK && status.active) begin
							pc_q    <= L_TICK;
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_RUN: begin
					if (uw.last) begin
						state_q <= ST_OUT;
					end else if (status.take) begin
						pc_q <= uw.target;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the program never runs past its last step
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (pc_q <= L_LAST))
		else $error("step counter left the program");

	// a tick on an idle sequence is answered without running the program
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && func == FUNC_TICK && !status.active) |=> out_valid)
		else $error("idle tick entered the program");

endmodule

/* rtl/pptsu_dp.sv */
// pptsu_dp: trajectory store, pointer and period registers, jump pointer reduction
// driven by pptsu_seq; depends on pptsu_pkg
module pptsu_dp
	import pptsu_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  seq_ctl_t           seq,
	input  cfg_t               cfg,
	input  logic [WADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0]  wr_data,
	output dp_status_t         status,
	output res_t               res
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [29:0] MOD_RECIP = 30'((64'd1 << 32) / STORE_DEPTH);
	localparam logic [AW-1:0] PTR_MAX = AW'(STORE_DEPTH - 1);

	logic [WORD_W-1:0] mem [STORE_DEPTH];
	logic [WORD_W-1:0] mem_rd_q;

	logic [AW-1:0]     ptr_q;
	play_t             mode_q;
	logic [WORD_W-1:0] pend_q, loopp_q, top_q, cmp_q;
	logic [31:0]       cnt_q, lim_q;
	logic              pre_q, now_q, tmr_q, run_q, act_q;
	logic [1:0]        err_q;

	logic [WORD_W-1:0] w_q, q_q, r_q;
	logic [45:0]       q_prod;
	logic [16:0]       r_ext, r_fix;

	logic [AW-1:0] ptr_fwd, ptr_back, raddr, waddr;
	logic          rd_en, wr_ok, take;
	uctl_t         uw;

	assign uw       = seq.uw;
	assign ptr_fwd  = (ptr_q == PTR_MAX) ? '0 : ptr_q + 1'b1;
	assign ptr_back = (ptr_q == '0) ? PTR_MAX : ptr_q - 1'b1;
	assign rd_en    = seq.step && uw.rd;
	assign waddr    = AW'(wr_addr);
	assign wr_ok    = seq.wr && (32'(wr_addr) < STORE_DEPTH);

	always_comb begin
		case (uw.asel)
			A_PTR:   raddr = ptr_q;
			A_FWD:   raddr = ptr_fwd;
			A_BACK:  raddr = ptr_back;
			A_CONST: raddr = AW'(uw.k);
			default: raddr = ptr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[waddr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[raddr];
		end
	end

	// jump pointer mod depth: reciprocal estimate, then one correction
	assign q_prod = 46'(w_q) * 46'(MOD_RECIP);
	assign r_ext  = {1'b0, r_q};
	assign r_fix  = (r_ext >= 17'(STORE_DEPTH)) ? r_ext - 17'(STORE_DEPTH) : r_ext;

	always_ff @(posedge clk) begin
		if (seq.step && uw.dop == D_SAVE_W) begin
			w_q <= mem_rd_q;
		end
		q_q <= 16'(q_prod >> 32);
		r_q <= 16'(32'(w_q) - 32'(q_q) * 32'(STORE_DEPTH));
	end

	always_comb begin
		case (uw.cond)
			C_NEXT:       take = 1'b0;
			C_ALWAYS:     take = 1'b1;
			C_RD_NE_BE:   take = (mem_rd_q != cfg.mk_be);
			C_RD_EQ_REV:  take = (mem_rd_q == cfg.mk_rev);
			C_RD_EQ_LOOP: take = (mem_rd_q == cfg.mk_loop);
			C_RD_EQ_NORM: take = (mem_rd_q == cfg.mk_norm);
			C_RD_NE_NORM: take = (mem_rd_q != cfg.mk_norm);
			C_W_EQ_LOOP:  take = (w_q == cfg.mk_loop);
			C_W_EQ_NORM:  take = (w_q == cfg.mk_norm);
			C_STOP_NOW:   take = now_q;
			C_STOP_PRE:   take = pre_q;
			C_MODE_LOOP:  take = (mode_q == PLAY_LOOP);
			C_MODE_REV:   take = (mode_q == PLAY_REV);
			C_CNT_NE_LIM: take = (cnt_q != lim_q);
			default:      take = 1'b0;
		endcase
	end

	assign status.take   = take;
	assign status.active = act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			mode_q  <= PLAY_NORMAL;
			pend_q  <= '0;
			loopp_q <= '0;
			cnt_q   <= '0;
			lim_q   <= '0;
			pre_q   <= 1'b0;
			now_q   <= 1'b0;
			tmr_q   <= 1'b0;
			top_q   <= '0;
			cmp_q   <= '0;
			run_q   <= 1'b0;
			act_q   <= 1'b0;
			err_q   <= '0;
		end else if (seq.step) begin
			case (uw.pop)
				P_HOLD:  ptr_q <= ptr_q;
				P_FWD:   ptr_q <= ptr_fwd;
				P_BACK:  ptr_q <= ptr_back;
				P_CONST: ptr_q <= AW'(uw.k);
				P_MOD:   ptr_q <= AW'(r_fix);
				default: ptr_q <= ptr_q;
			endcase
			case (uw.mop)
				M_HOLD:   mode_q <= mode_q;
				M_NORMAL: mode_q <= PLAY_NORMAL;
				M_LOOP:   mode_q <= PLAY_LOOP;
				M_REV:    mode_q <= PLAY_REV;
				default:  mode_q <= mode_q;
			endcase
			case (uw.dop)
				D_NONE, D_SAVE_W: begin
				end
				D_CLR_RUN: begin
					pre_q <= 1'b0;
					now_q <= 1'b0;
					tmr_q <= 1'b0;
					run_q <= 1'b0;
					act_q <= 1'b0;
				end
				D_SET_ERR: err_q <= uw.k[1:0];
				D_LD_PEND_LPP: begin
					pend_q  <= mem_rd_q;
					loopp_q <= mem_rd_q;
					cnt_q   <= '0;
				end
				D_LIM_HI: lim_q[31:16] <= mem_rd_q;
				D_LIM_LO: begin
					lim_q[15:0] <= mem_rd_q;
					cnt_q       <= '0;
				end
				D_LD_PEND:  pend_q  <= mem_rd_q;
				D_SET_PRE:  pre_q   <= 1'b1;
				D_GO: begin
					err_q <= '0;
					top_q <= pend_q;
					cmp_q <= cfg.duty;
					run_q <= 1'b1;
					act_q <= 1'b1;
				end
				D_TOP_PEND: top_q   <= pend_q;
				D_LD_LOOPP: loopp_q <= mem_rd_q;
				D_LOOP_STEP: begin
					pend_q <= loopp_q;
					cnt_q  <= cnt_q + 1'b1;
				end
				D_SET_NOW: now_q <= 1'b1;
				D_STOP_STEP: begin
					cmp_q <= CMP_STOP;
					if (tmr_q) begin
						run_q <= 1'b0;
						act_q <= 1'b0;
					end
					tmr_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign res.period_top      = top_q;
	assign res.compare_value   = cmp_q;
	assign res.timer_running   = run_q;
	assign res.sequence_active = act_q;
	assign res.error_code      = err_q;

	// the timer only runs inside an active sequence
	a_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> act_q)
		else $error("timer running without an active sequence");

	// the timer-stop stage is only reached through the compare stage
	a_stop_order: assert property (@(posedge clk) disable iff (!arst_n)
		tmr_q |-> now_q)
		else $error("timer stop armed before compare stop");

endmodule

/* dv/pwm_period_trajectory_sequencer_unit_test.sv */
// Self-checking bench for the PWM period trajectory sequencer: directed table, then
// random trajectories under several marker settings, checked against an in-bench predictor.
// Depends on pptsu_pkg and pwm_period_trajectory_sequencer_unit.
module pwm_period_trajectory_sequencer_unit_test;
	import pptsu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 1024;

	localparam logic [1:0] FUNC_IDLE = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_BAD_BEGIN = 2'd1;
	localparam logic [1:0] ERR_REV_FIRST = 2'd2;
	localparam logic [1:0] ERR_BAD_MODE  = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  data;
		logic               fixed;
		res_t               want;
	} row_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata   = '0;
	logic [1:0]           s_tuser   = FUNC_IDLE;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [39:0]          m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MARK_BE;
	logic [WORD_W-1:0]    cfg_data  = '0;

	pwm_period_trajectory_sequencer_unit #(.STORE_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [WORD_W-1:0] shadow [DEPTH];
	cfg_t              mk;
	int                ptr;
	play_t             walk;
	logic [WORD_W-1:0] next_top, rep_top;
	logic [31:0]       rep_cnt, rep_lim;
	logic              arm_pre, arm_now, arm_halt;
	logic [WORD_W-1:0] top_q, cmp_q;
	logic              run_q, act_q;
	logic [1:0]        err_q;

	res_t              outputs_due [$];
	logic [WORD_W-1:0] traj_words [$];
	row_t              script [26];

	int mismatches = 0;
	int item_count = 0;
	int burst_left = 0;
	bit lazy_send  = 0;

	int rx_span = 0;
	int rx_mode = 0;
	int rx_run  = 0;
	bit rx_on   = 1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [WORD_W-1:0] peek(int a);
		return shadow[a % DEPTH];
	endfunction

	function automatic res_t outs(logic [15:0] top, logic [15:0] cmp, logic run, logic act,
			logic [1:0] err);
		res_t r;
		r.period_top      = top;
		r.compare_value   = cmp;
		r.timer_running   = run;
		r.sequence_active = act;
		r.error_code      = err;
		return r;
	endfunction

	task automatic advance_sequencer(input logic [1:0] f, input logic [WADDR_W-1:0] a,
			input logic [WORD_W-1:0] d, output res_t r);
		logic [WORD_W-1:0] w, hi, lo;
		bit ok;
		ok = 0;
		case (f)
			FUNC_WRITE: begin
				if (a < DEPTH) shadow[a] = d;
			end
			FUNC_START: begin
				arm_pre  = 0;
				arm_now  = 0;
				arm_halt = 0;
				act_q    = 0;
				run_q    = 0;
				if (peek(0) != mk.mk_be) begin
					err_q = ERR_BAD_BEGIN;
				end else begin
					w = peek(1);
					if (w == mk.mk_rev) begin
						err_q = ERR_REV_FIRST;
					end else if (w == mk.mk_loop) begin
						next_top = peek(2);
						rep_top  = next_top;
						rep_cnt  = 0;
						rep_lim  = {peek(3), peek(4)};
						ptr      = 5 % DEPTH;
						walk     = PLAY_LOOP;
						ok       = 1;
					end else if (w == mk.mk_norm) begin
						next_top = peek(2);
						ptr      = 3 % DEPTH;
						walk     = PLAY_NORMAL;
						if (peek(ptr) == mk.mk_be) arm_pre = 1;
						ok       = 1;
					end else begin
						err_q = ERR_BAD_MODE;
					end
				end
				if (ok) begin
					err_q = ERR_NONE;
					top_q = next_top;
					cmp_q = mk.duty;
					run_q = 1;
					act_q = 1;
				end
			end
			FUNC_TICK: begin
				if (act_q) begin
					top_q = next_top;
					if (arm_now) begin
						cmp_q = CMP_STOP;
						if (arm_halt) begin
							run_q = 0;
							act_q = 0;
						end
						arm_halt = 1;
					end else if (arm_pre) begin
						arm_now = 1;
					end else begin
						case (walk)
							PLAY_LOOP: begin
								next_top = rep_top;
								rep_cnt  = rep_cnt + 1;
								if (rep_cnt == rep_lim) begin
									w = peek(ptr);
									if (w == mk.mk_norm) begin
										ptr  = (ptr + 1) % DEPTH;
										walk = PLAY_NORMAL;
									end else if (w == mk.mk_rev) begin
										ptr  = int'(peek(ptr + 1)) % DEPTH;
										walk = PLAY_REV;
									end else if (w == mk.mk_be) begin
										arm_now = 1;
									end
								end
							end
							PLAY_REV: begin
								next_top = peek(ptr);
								ptr      = (ptr + DEPTH - 1) % DEPTH;
								if (peek(ptr) == mk.mk_norm) begin
									ptr = (ptr + DEPTH - 1) % DEPTH;
									if (peek(ptr) == mk.mk_be) arm_pre = 1;
								end
							end
							default: begin
								next_top = peek(ptr);
								ptr      = (ptr + 1) % DEPTH;
								w        = peek(ptr);
								if (w == mk.mk_rev) begin
									walk = PLAY_REV;
									ptr  = int'(peek(ptr + 1)) % DEPTH;
								end else if (w == mk.mk_loop) begin
									ptr     = (ptr + 1) % DEPTH;
									rep_top = peek(ptr);
									ptr     = (ptr + 1) % DEPTH;
									hi      = peek(ptr);
									ptr     = (ptr + 1) % DEPTH;
									lo      = peek(ptr);
									ptr     = (ptr + 1) % DEPTH;
									rep_lim = {hi, lo};
									rep_cnt = 0;
									walk    = PLAY_LOOP;
								end else if (w == mk.mk_be) begin
									arm_pre = 1;
								end
							end
						endcase
					end
				end
			end
			default: ;
		endcase
		r = outs(top_q, cmp_q, run_q, act_q, err_q);
	endtask

	task automatic put_item(input logic [1:0] f, input logic [WADDR_W-1:0] a,
			input logic [WORD_W-1:0] d, input logic fixed = 1'b0, input res_t want = '0);
		res_t r;
		int gap;
		if (lazy_send && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		if (burst_left > 0) burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {6'b0, d, a};
		do @(posedge clk); while (!s_tready);
		item_count++;
		advance_sequencer(f, a, d, r);
		outputs_due.push_back(fixed ? want : r);
	endtask

	// hold the sender until every outstanding result has been taken
	task automatic drain();
		@(negedge clk) s_tvalid <= 1'b0;
		burst_left = 0;
		while (outputs_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_markers(logic [15:0] be, logic [15:0] norm, logic [15:0] lp,
			logic [15:0] rv, logic [15:0] duty);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MARK_BE;
		cfg_data  <= be;
		@(negedge clk);
		cfg_index <= CFG_MARK_NORM;
		cfg_data  <= norm;
		@(negedge clk);
		cfg_index <= CFG_MARK_LOOP;
		cfg_data  <= lp;
		@(negedge clk);
		cfg_index <= CFG_MARK_REV;
		cfg_data  <= rv;
		@(negedge clk);
		cfg_index <= CFG_DUTY;
		cfg_data  <= duty;
		@(negedge clk) cfg_we <= 1'b0;
		mk.mk_be   = be;
		mk.mk_norm = norm;
		mk.mk_loop = lp;
		mk.mk_rev  = rv;
		mk.duty    = duty;
	endtask

	function automatic void add_periods();
		repeat ($urandom_range(1, 4)) traj_words.push_back(WORD_W'($urandom_range(0, 65535)));
	endfunction

	// loop header: marker, period, count high, count low
	function automatic void add_loop();
		traj_words.push_back(mk.mk_loop);
		traj_words.push_back(WORD_W'($urandom_range(0, 65535)));
		traj_words.push_back(($urandom_range(0, 19) == 0) ?
			WORD_W'($urandom_range(0, 65535)) : 16'd0);
		traj_words.push_back(($urandom_range(0, 9) == 0) ?
			WORD_W'($urandom_range(0, 65535)) : WORD_W'($urandom_range(1, 4)));
	endfunction

	task automatic play_trajectory();
		int kind, segs, cap, n, norm_end, pick;
		bit in_loop;
		traj_words.delete();
		traj_words.push_back(mk.mk_be);
		norm_end = 0;
		in_loop  = 0;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			traj_words[0] = WORD_W'($urandom_range(0, 65535));
			traj_words.push_back(mk.mk_norm);
			add_periods();
		end else if (kind < 11) begin
			traj_words.push_back(mk.mk_rev);
			add_periods();
		end else if (kind < 15) begin
			traj_words.push_back(WORD_W'($urandom_range(0, 65535)));
			add_periods();
		end else begin
			if (kind < 60) begin
				traj_words.push_back(mk.mk_norm);
				add_periods();
				norm_end = traj_words.size() - 1;
			end else begin
				add_loop();
				in_loop = 1;
			end
			segs = $urandom_range(0, 3);
			repeat (segs) begin
				if (in_loop) begin
					traj_words.push_back(mk.mk_norm);
					add_periods();
				end else begin
					add_loop();
				end
				in_loop = !in_loop;
			end
			pick = $urandom_range(0, 3);
			if (pick == 0 && norm_end != 0) begin
				// jump back into the opening segment, pointer carries junk above the depth
				traj_words.push_back(mk.mk_rev);
				traj_words.push_back(WORD_W'($urandom_range(2, norm_end)
					+ DEPTH * $urandom_range(0, 63)));
			end else if (pick == 1) begin
				traj_words.push_back(mk.mk_rev);
				traj_words.push_back(WORD_W'($urandom_range(0, 65535)));
			end else begin
				traj_words.push_back(mk.mk_be);
			end
		end
		foreach (traj_words[i]) put_item(FUNC_WRITE, WADDR_W'(i), traj_words[i]);
		put_item(FUNC_START, WADDR_W'($urandom_range(0, 1023)), WORD_W'($urandom_range(0, 65535)));
		cap = 2 * traj_words.size() + 12;
		n = 0;
		while (act_q && n < cap) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				put_item(FUNC_WRITE, WADDR_W'($urandom_range(0, 1023)),
					WORD_W'($urandom_range(0, 65535)));
			end else if (pick < 9) begin
				put_item(FUNC_IDLE, WADDR_W'($urandom_range(0, 1023)),
					WORD_W'($urandom_range(0, 65535)));
			end else if (pick < 11) begin
				put_item(FUNC_START, WADDR_W'($urandom_range(0, 1023)),
					WORD_W'($urandom_range(0, 65535)));
			end
			put_item(FUNC_TICK, WADDR_W'($urandom_range(0, 1023)),
				WORD_W'($urandom_range(0, 65535)));
			n++;
		end
		if ($urandom_range(0, 3) == 0) put_item(FUNC_TICK, '0, '0);
	endtask

	task automatic run_phase(int quota);
		int first;
		first = item_count;
		while (item_count - first < quota) begin
			play_trajectory();
			if ($urandom_range(0, 4) == 0) drain();
		end
	endtask

	task automatic mismatch(string msg);
		if (mismatches < 40) $display("mismatch at %0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		res_t got, want;
		if (m_tvalid && m_tready) begin
			got.period_top      = m_tdata[15:0];
			got.compare_value   = m_tdata[31:16];
			got.timer_running   = m_tdata[32];
			got.sequence_active = m_tdata[33];
			got.error_code      = m_tdata[35:34];
			if (outputs_due.size() == 0) begin
				mismatch("result with no item waiting");
			end else begin
				want = outputs_due.pop_front();
				if (got.period_top !== want.period_top)
					mismatch($sformatf("period_top %h, want %h", got.period_top,
						want.period_top));
				if (got.compare_value !== want.compare_value)
					mismatch($sformatf("compare_value %h, want %h", got.compare_value,
						want.compare_value));
				if (got.timer_running !== want.timer_running)
					mismatch($sformatf("timer_running %b, want %b", got.timer_running,
						want.timer_running));
				if (got.sequence_active !== want.sequence_active)
					mismatch($sformatf("sequence_active %b, want %b", got.sequence_active,
						want.sequence_active));
				if (got.error_code !== want.error_code)
					mismatch($sformatf("error_code %0d, want %0d", got.error_code,
						want.error_code));
			end
		end
	end

	// receiver: switches between always ready, coin flips, long stalls and rare stalls
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_span = $urandom_range(50, 400);
			rx_mode = $urandom_range(0, 3);
		end
		rx_span--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: begin
				if (rx_run == 0) begin
					rx_on  = !rx_on;
					rx_run = $urandom_range(1, 20);
				end
				rx_run--;
				m_tready <= rx_on;
			end
			default: m_tready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	initial begin
		mk       = {16'd0, 16'd1, 16'd2, 16'd3, DUTY_RESET};
		ptr      = 0;
		walk     = PLAY_NORMAL;
		next_top = '0;
		rep_top  = '0;
		rep_cnt  = '0;
		rep_lim  = '0;
		arm_pre  = 0;
		arm_now  = 0;
		arm_halt = 0;
		top_q    = '0;
		cmp_q    = '0;
		run_q    = 0;
		act_q    = 0;
		err_q    = ERR_NONE;

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// fill the whole store so no read ever lands on an unwritten word
		for (int i = 0; i < DEPTH; i++)
			put_item(FUNC_WRITE, WADDR_W'(i), WORD_W'($urandom_range(0, 65535)));

		script = '{
			'{FUNC_TICK,  10'd0,    16'h0000, 1'b1, outs(0, 0, 0, 0, ERR_NONE)},
			'{FUNC_IDLE,  10'h3FF,  16'hFFFF, 1'b1, outs(0, 0, 0, 0, ERR_NONE)},
			'{FUNC_WRITE, 10'd0,    16'h0001, 1'b0, res_t'(0)},
			'{FUNC_START, 10'd0,    16'h0000, 1'b1, outs(0, 0, 0, 0, ERR_BAD_BEGIN)},
			'{FUNC_WRITE, 10'd0,    16'h0000, 1'b0, res_t'(0)},
			'{FUNC_WRITE, 10'd1,    16'h0003, 1'b0, res_t'(0)},
			'{FUNC_START, 10'd0,    16'h0000, 1'b1, outs(0, 0, 0, 0, ERR_REV_FIRST)},
			'{FUNC_WRITE, 10'd1,    16'hFFFF, 1'b0, res_t'(0)},
			'{FUNC_START, 10'd0,    16'h0000, 1'b1, outs(0, 0, 0, 0, ERR_BAD_MODE)},
			'{FUNC_WRITE, 10'd1,    16'h0001, 1'b0, res_t'(0)},
			'{FUNC_WRITE, 10'd2,    16'hFFFF, 1'b0, res_t'(0)},
			'{FUNC_WRITE, 10'd3,    16'h0000, 1'b0, res_t'(0)},
			// one-period trajectory: end marker right behind the first period
			'{FUNC_START, 10'd0,    16'h0000, 1'b1, outs(16'hFFFF, DUTY_RESET, 1, 1, ERR_NONE)},
			'{FUNC_TICK,  10'd0,    16'h0000, 1'b0, res_t'(0)},
			'{FUNC_TICK,  10'd0,    16'h0000, 1'b0, res_t'(0)},
			'{FUNC_TICK,  10'd0,    16'h0000, 1'b1, outs(16'hFFFF, CMP_STOP, 0, 0, ERR_NONE)},
			'{FUNC_WRITE, 10'h3FF,  16'hFFFF, 1'b0, res_t'(0)},
			// loop of one tick with period zero, then end marker
			'{FUNC_WRITE, 10'd1,    16'h0002, 1'b0, res_t'(0)},
			'{FUNC_WRITE, 10'd2,    16'h0000, 1'b0, res_t'(0)},
			'{FUNC_WRITE, 10'd3,    16'h0000, 1'b0, res_t'(0)},
			'{FUNC_WRITE, 10'd4,    16'h0001, 1'b0, res_t'(0)},
			'{FUNC_WRITE, 10'd5,    16'h0000, 1'b0, res_t'(0)},
			'{FUNC_START, 10'd0,    16'h0000, 1'b1, outs(0, DUTY_RESET, 1, 1, ERR_NONE)},
			'{FUNC_TICK,  10'd0,    16'h0000, 1'b0, res_t'(0)},
			'{FUNC_TICK,  10'd0,    16'h0000, 1'b0, res_t'(0)},
			'{FUNC_TICK,  10'd0,    16'h0000, 1'b1, outs(0, CMP_STOP, 0, 0, ERR_NONE)}
		};
		foreach (script[i])
			put_item(script[i].func, script[i].addr, script[i].data, script[i].fixed,
				script[i].want);

		lazy_send = 1;
		set_markers(16'd0, 16'd1, 16'd2, 16'd3, DUTY_RESET);
		run_phase(65);
		lazy_send = 0;
		set_markers(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF);
		run_phase(65);
		lazy_send = 1;
		set_markers(16'h1234, 16'hFFFE, 16'h0001, 16'hABCD, 16'h0000);
		run_phase(65);
		// normal and loop share a code
		lazy_send = 0;
		set_markers(16'd5, 16'd9, 16'd9, 16'd11, WORD_W'($urandom_range(0, 65535)));
		run_phase(65);
		// begin/end and reverse share a code
		lazy_send = 1;
		set_markers(16'h00AA, 16'h0055, 16'h0066, 16'h00AA, 16'd1);
		run_phase(65);
		set_markers(WORD_W'($urandom_range(0, 65535)), WORD_W'($urandom_range(0, 65535)),
			WORD_W'($urandom_range(0, 65535)), WORD_W'($urandom_range(0, 65535)),
			WORD_W'($urandom_range(0, 65535)));
		run_phase(65);
		lazy_send = 0;
		set_markers(16'd0, 16'd1, 16'd2, 16'd3, 16'h8001);
		run_phase(65);

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
